// ----- rtl/camera_ray_direction_macros.svh -----
// Assertion helpers for the top-level file, which checks its own logic.
`ifndef CAMERA_RAY_DIRECTION_MACROS_SVH
`define CAMERA_RAY_DIRECTION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRD_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("check failed: label");

// Next-cycle implication, checked outside reset.
`define CRD_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("check failed: label");

`endif

// ----- rtl/crd_pkg.sv -----
package crd_pkg;

	localparam int COMP_W = 20;
	localparam int VEC_W = 3 * COMP_W;
	localparam int COORD_W = 16;
	localparam int PROD_W = 37;
	localparam int MAG_W = 38;
	localparam int POS_W = 6;
	localparam int NRM_W = 30;
	localparam int SQR_W = 60;
	localparam int SUM_W = 62;
	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int REM_W = 36;
	localparam int LEN_W = 31;
	localparam int Q_W = 15;
	localparam int NUM_W = 45;
	localparam int DIR_W = 16;
	localparam int SQRT_STAGES = 16;
	localparam int DIV_STAGES = 5;
	localparam int DIV_STEPS = 3;

	localparam logic [1:0] REG_ORIGIN = 2'd0;
	localparam logic [1:0] REG_LOWER_LEFT = 2'd1;
	localparam logic [1:0] REG_HORIZONTAL = 2'd2;
	localparam logic [1:0] REG_VERTICAL = 2'd3;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t [2:0] vec_t;

	typedef struct packed {
		vec_t o;
		vec_t ll;
		vec_t h;
		vec_t vt;
	} cam_t;

	typedef struct packed {
		logic [2:0][NRM_W-1:0] mag;
		logic [2:0] neg;
		logic degen;
	} side_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0] rem;
	} sqrt_t;

	typedef struct packed {
		logic [LEN_W-1:0] r;
		logic [Q_W-1:0] nq;
	} div_t;

	typedef div_t [2:0] lanes_t;

endpackage

// ----- rtl/crd_front.sv -----
module crd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [crd_pkg::COORD_W-1:0] u,
	input  logic [crd_pkg::COORD_W-1:0] v,
	input  crd_pkg::cam_t cam,
	output logic v_out,
	output logic [2:0][crd_pkg::MAG_W-1:0] mag_s3,
	output logic [2:0] neg_s3,
	output logic degen_s3,
	output logic [crd_pkg::POS_W-1:0] pos_s3
);
	logic v_s1, v_s2;
	logic signed [crd_pkg::PROD_W-1:0] base_s1 [3];
	logic signed [crd_pkg::PROD_W-1:0] hu_s1 [3];
	logic signed [crd_pkg::PROD_W-1:0] vv_s1 [3];
	logic [crd_pkg::MAG_W-1:0] mag_s2 [3];
	logic [2:0] neg_s2;
	logic [crd_pkg::MAG_W-1:0] or_all;
	logic [crd_pkg::POS_W-1:0] pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_out <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				base_s1[c] <= crd_pkg::PROD_W'(
					(($signed((crd_pkg::COMP_W+1)'(cam.ll[c])) -
					  $signed((crd_pkg::COMP_W+1)'(cam.o[c]))) <<< crd_pkg::COORD_W-1));
				hu_s1[c] <= cam.h[c] * $signed({1'b0, u});
				vv_s1[c] <= cam.vt[c] * $signed({1'b0, v});
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [crd_pkg::MAG_W-1:0] d;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				d = crd_pkg::MAG_W'(base_s1[c]) + crd_pkg::MAG_W'(hu_s1[c]) +
					crd_pkg::MAG_W'(vv_s1[c]);
				neg_s2[c] <= d[crd_pkg::MAG_W-1];
				mag_s2[c] <= d[crd_pkg::MAG_W-1] ? crd_pkg::MAG_W'(-d) : crd_pkg::MAG_W'(d);
			end
		end
	end

	// The leading one of the OR of the magnitudes is the leading one of the largest.
	always_comb begin
		or_all = mag_s2[0] | mag_s2[1] | mag_s2[2];
		pos = '0;
		for (int i = 0; i < crd_pkg::MAG_W; i++) begin
			if (or_all[i]) begin
				pos = crd_pkg::POS_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				mag_s3[c] <= mag_s2[c];
			end
			neg_s3 <= neg_s2;
			degen_s3 <= (or_all == '0);
			pos_s3 <= pos;
		end
	end
endmodule

// ----- rtl/crd_norm.sv -----
module crd_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [2:0][crd_pkg::MAG_W-1:0] mag,
	input  logic [2:0] neg,
	input  logic degen,
	input  logic [crd_pkg::POS_W-1:0] pos,
	output logic v_out,
	output logic [crd_pkg::SUM_W-1:0] sum_s6,
	output crd_pkg::side_t side_s6
);
	localparam logic [crd_pkg::POS_W-1:0] TOP = crd_pkg::POS_W'(crd_pkg::NRM_W - 1);

	logic v_s4, v_s5;
	crd_pkg::side_t side_s4, side_s5;
	logic [crd_pkg::SQR_W-1:0] sq_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_out <= 1'b0;
		end else if (en) begin
			v_s4 <= v_in;
			v_s5 <= v_s4;
			v_out <= v_s5;
		end
	end

	// Bring the largest magnitude into [2^29, 2^30); a right shift truncates.
	always_ff @(posedge clk) begin
		logic [crd_pkg::MAG_W-1:0] sh;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				if (pos > TOP) begin
					sh = mag[c] >> (pos - TOP);
				end else begin
					sh = mag[c] << (TOP - pos);
				end
				side_s4.mag[c] <= sh[crd_pkg::NRM_W-1:0];
			end
			side_s4.neg <= neg;
			side_s4.degen <= degen;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				sq_s5[c] <= side_s4.mag[c] * side_s4.mag[c];
			end
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= crd_pkg::SUM_W'(sq_s5[0]) + crd_pkg::SUM_W'(sq_s5[1]) +
				crd_pkg::SUM_W'(sq_s5[2]);
			side_s6 <= side_s5;
		end
	end
endmodule

// ----- rtl/crd_sqrt_stage.sv -----
module crd_sqrt_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  crd_pkg::sqrt_t st_in,
	input  crd_pkg::side_t side_in,
	output logic v_out,
	output crd_pkg::sqrt_t st_q,
	output crd_pkg::side_t side_q
);
	crd_pkg::sqrt_t nxt;

	// Two digits of the restoring square root, two radicand bits each.
	always_comb begin
		logic [crd_pkg::REM_W-1:0] t;
		nxt = st_in;
		for (int k = 0; k < 2; k++) begin
			nxt.rem = {nxt.rem[crd_pkg::REM_W-3:0], nxt.rad[crd_pkg::RAD_W-1 -: 2]};
			nxt.rad = {nxt.rad[crd_pkg::RAD_W-3:0], 2'b00};
			t = crd_pkg::REM_W'({nxt.root, 2'b01});
			if (nxt.rem >= t) begin
				nxt.rem = nxt.rem - t;
				nxt.root = {nxt.root[crd_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				nxt.root = {nxt.root[crd_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= nxt;
			side_q <= side_in;
		end
	end
endmodule

// ----- rtl/crd_div_stage.sv -----
module crd_div_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  logic [crd_pkg::LEN_W-1:0] len_in,
	input  crd_pkg::lanes_t ln_in,
	input  crd_pkg::side_t side_in,
	output logic v_out,
	output logic [crd_pkg::LEN_W-1:0] len_q,
	output crd_pkg::lanes_t ln_q,
	output crd_pkg::side_t side_q
);
	crd_pkg::lanes_t nxt;

	// Each lane shifts numerator bits in at the bottom and quotient bits replace them.
	always_comb begin
		logic [crd_pkg::LEN_W:0] t;
		nxt = ln_in;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < crd_pkg::DIV_STEPS; k++) begin
				t = {nxt[c].r, nxt[c].nq[crd_pkg::Q_W-1]};
				if (t >= (crd_pkg::LEN_W+1)'(len_in)) begin
					nxt[c].r = crd_pkg::LEN_W'(t - (crd_pkg::LEN_W+1)'(len_in));
					nxt[c].nq = {nxt[c].nq[crd_pkg::Q_W-2:0], 1'b1};
				end else begin
					nxt[c].r = t[crd_pkg::LEN_W-1:0];
					nxt[c].nq = {nxt[c].nq[crd_pkg::Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln_q <= nxt;
			len_q <= len_in;
			side_q <= side_in;
		end
	end
endmodule

// ----- rtl/camera_ray_direction.sv -----
// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/tready   tdata: screen_u, screen_v
// m_*       out        m_tvalid/tready   tdata: dir_x, dir_y, dir_z; tuser: degenerate
// apb       in         psel/penable      four 60-bit camera vectors at 8*i
//
// One request enters per cycle while no result is stalled at the output.
// Most of the depth comes from the square root (16 stages of two digits) and the three
// dividers (5 stages of three quotient bits).
// The whole pipeline advances together; while a result waits at the output,
// every stage holds and s_tready is low.
// Reset clears the valid bits and the camera vectors.
module camera_ray_direction (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata,  // screen_u [15:0], screen_v [31:16]
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata,  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
	output logic [0:0] m_tuser,   // degenerate [0]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	logic [crd_pkg::VEC_W-1:0] origin_q, lower_left_q, horizontal_q, vertical_q;
	crd_pkg::cam_t cam;
	logic en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			lower_left_q <= '0;
			horizontal_q <= '0;
			vertical_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				crd_pkg::REG_ORIGIN: origin_q <= pwdata[crd_pkg::VEC_W-1:0];
				crd_pkg::REG_LOWER_LEFT: lower_left_q <= pwdata[crd_pkg::VEC_W-1:0];
				crd_pkg::REG_HORIZONTAL: horizontal_q <= pwdata[crd_pkg::VEC_W-1:0];
				crd_pkg::REG_VERTICAL: vertical_q <= pwdata[crd_pkg::VEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			crd_pkg::REG_ORIGIN: prdata = 64'(origin_q);
			crd_pkg::REG_LOWER_LEFT: prdata = 64'(lower_left_q);
			crd_pkg::REG_HORIZONTAL: prdata = 64'(horizontal_q);
			crd_pkg::REG_VERTICAL: prdata = 64'(vertical_q);
			default: prdata = '0;
		endcase
	end

	assign cam.o = crd_pkg::vec_t'(origin_q);
	assign cam.ll = crd_pkg::vec_t'(lower_left_q);
	assign cam.h = crd_pkg::vec_t'(horizontal_q);
	assign cam.vt = crd_pkg::vec_t'(vertical_q);

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic v_f;
	logic [2:0][crd_pkg::MAG_W-1:0] mag_f;
	logic [2:0] neg_f;
	logic degen_f;
	logic [crd_pkg::POS_W-1:0] pos_f;

	crd_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(s_tvalid),
		.u(s_tdata[15:0]), .v(s_tdata[31:16]), .cam(cam),
		.v_out(v_f), .mag_s3(mag_f), .neg_s3(neg_f), .degen_s3(degen_f), .pos_s3(pos_f)
	);

	logic v_n;
	logic [crd_pkg::SUM_W-1:0] sum_n;
	crd_pkg::side_t side_n;

	crd_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_f),
		.mag(mag_f), .neg(neg_f), .degen(degen_f), .pos(pos_f),
		.v_out(v_n), .sum_s6(sum_n), .side_s6(side_n)
	);

	logic v_sq [crd_pkg::SQRT_STAGES+1];
	crd_pkg::sqrt_t st_sq [crd_pkg::SQRT_STAGES+1];
	crd_pkg::side_t side_sq [crd_pkg::SQRT_STAGES+1];

	assign v_sq[0] = v_n;
	assign st_sq[0].rad = crd_pkg::RAD_W'(sum_n);
	assign st_sq[0].root = '0;
	assign st_sq[0].rem = '0;
	assign side_sq[0] = side_n;

	for (genvar g = 0; g < crd_pkg::SQRT_STAGES; g++) begin : g_sqrt
		crd_sqrt_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_sq[g]),
			.st_in(st_sq[g]), .side_in(side_sq[g]),
			.v_out(v_sq[g+1]), .st_q(st_sq[g+1]), .side_q(side_sq[g+1])
		);
	end

	// Numerator m*16384 + L/2, so the quotient rounds half away from zero.
	logic v_num_s1;
	logic [crd_pkg::LEN_W-1:0] len_num_s1;
	crd_pkg::lanes_t ln_num_s1;
	crd_pkg::side_t side_num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_num_s1 <= 1'b0;
		end else if (en) begin
			v_num_s1 <= v_sq[crd_pkg::SQRT_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		logic [crd_pkg::LEN_W-1:0] len;
		logic [crd_pkg::NUM_W-1:0] num;
		if (en) begin
			len = st_sq[crd_pkg::SQRT_STAGES].root[crd_pkg::LEN_W-1:0];
			for (int c = 0; c < 3; c++) begin
				num = {1'b0, side_sq[crd_pkg::SQRT_STAGES].mag[c], 14'b0} +
					crd_pkg::NUM_W'(len >> 1);
				ln_num_s1[c].r <= crd_pkg::LEN_W'(num[crd_pkg::NUM_W-1:crd_pkg::Q_W]);
				ln_num_s1[c].nq <= num[crd_pkg::Q_W-1:0];
			end
			len_num_s1 <= len;
			side_num_s1 <= side_sq[crd_pkg::SQRT_STAGES];
		end
	end

	logic v_dv [crd_pkg::DIV_STAGES+1];
	logic [crd_pkg::LEN_W-1:0] len_dv [crd_pkg::DIV_STAGES+1];
	crd_pkg::lanes_t ln_dv [crd_pkg::DIV_STAGES+1];
	crd_pkg::side_t side_dv [crd_pkg::DIV_STAGES+1];

	assign v_dv[0] = v_num_s1;
	assign len_dv[0] = len_num_s1;
	assign ln_dv[0] = ln_num_s1;
	assign side_dv[0] = side_num_s1;

	for (genvar g = 0; g < crd_pkg::DIV_STAGES; g++) begin : g_div
		crd_div_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_dv[g]),
			.len_in(len_dv[g]), .ln_in(ln_dv[g]), .side_in(side_dv[g]),
			.v_out(v_dv[g+1]), .len_q(len_dv[g+1]), .ln_q(ln_dv[g+1]),
			.side_q(side_dv[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_dv[crd_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		logic [crd_pkg::DIR_W-1:0] q;
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				q = crd_pkg::DIR_W'(ln_dv[crd_pkg::DIV_STAGES][c].nq);
				if (side_dv[crd_pkg::DIV_STAGES].degen) begin
					m_tdata[c*crd_pkg::DIR_W +: crd_pkg::DIR_W] <= '0;
				end else if (side_dv[crd_pkg::DIV_STAGES].neg[c]) begin
					m_tdata[c*crd_pkg::DIR_W +: crd_pkg::DIR_W] <= -q;
				end else begin
					m_tdata[c*crd_pkg::DIR_W +: crd_pkg::DIR_W] <= q;
				end
			end
			m_tuser[0] <= side_dv[crd_pkg::DIV_STAGES].degen;
		end
	end

	logic signed [crd_pkg::DIR_W-1:0] dx;
	assign dx = m_tdata[15:0];

`include "camera_ray_direction_macros.svh"

	`CRD_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[0], m_tdata == '0)
	`CRD_ASSERT_NOW(a_unit_range, m_tvalid && !m_tuser[0], (dx <= 16'sd16384) && (dx >= -16'sd16384))
	`CRD_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready)
endmodule

// ----- test/tb_camera_ray_direction.sv -----
module tb_camera_ray_direction;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic degen;
	} ray_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	logic [59:0] cam_regs [4];
	ray_t pending_rays [$];
	int errors = 0;
	int idle_cycles = 0;
	bit rx_stall_free = 1'b0;
	localparam int WATCHDOG = 5000;

	camera_ray_direction dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [63:0] comp(logic [59:0] p, int i);
		logic signed [19:0] c;
		c = p[i*20 +: 20];
		return 64'(c);
	endfunction

	function automatic logic [63:0] root64(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic ray_t trace_ray(logic [15:0] u, logic [15:0] v);
		ray_t r;
		logic signed [63:0] d;
		logic [63:0] mag [3];
		logic [63:0] mx, len, q;
		logic neg [3];
		mx = 0;
		for (int c = 0; c < 3; c++) begin
			d = comp(cam_regs[crd_pkg::REG_LOWER_LEFT], c) * 32768
				+ comp(cam_regs[crd_pkg::REG_HORIZONTAL], c) * $signed({48'd0, u})
				+ comp(cam_regs[crd_pkg::REG_VERTICAL], c) * $signed({48'd0, v})
				- comp(cam_regs[crd_pkg::REG_ORIGIN], c) * 32768;
			neg[c] = d < 0;
			mag[c] = neg[c] ? -d : d;
			if (mag[c] > mx) mx = mag[c];
		end
		r = '0;
		if (mx == 0) begin
			r.degen = 1'b1;
			return r;
		end
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			for (int c = 0; c < 3; c++) mag[c] = mag[c] >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx = mx << 1;
			for (int c = 0; c < 3; c++) mag[c] = mag[c] << 1;
		end
		len = root64(mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]);
		for (int c = 0; c < 3; c++) begin
			q = (mag[c] * 16384 + len / 2) / len;
			if (q > 16384) q = 16384;
			q = neg[c] ? -q : q;
			case (c)
				0: r.x = q[15:0];
				1: r.y = q[15:0];
				default: r.z = q[15:0];
			endcase
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("%0t: watchdog timeout", $time);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Output checker and random back-pressure.
	initial begin
		ray_t want, got;
		int wait_n;
		@(posedge arst_n);
		forever begin
			wait_n = rx_stall_free ? 0 : $urandom_range(0, 16);
			if (wait_n > 0) begin
				m_tready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser[0]};
			if (pending_rays.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_rays.pop_front();
				if (got !== want) begin
					$display("%0t: expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	task automatic send_ray(logic [15:0] u, logic [15:0] v, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, u};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_rays.push_back(trace_ray(u, v));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [59:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= {4'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cam_regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_rays.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [59:0] rand_vec();
		return {20'($urandom_range(0, 1) ? (32'h80000 | $urandom) : $urandom),
			20'($urandom), 20'($urandom)};
	endfunction

	task automatic test_reset_degenerate();
		send_ray(16'd0, 16'd0);
		send_ray(16'hFFFF, 16'hFFFF);
		drain();
	endtask

	task automatic test_extremes();
		logic [59:0] ext [4];
		ext = '{60'h80000_80000_80000, 60'h7FFFF_7FFFF_7FFFF,
			60'hFFFFF_00001_80000, 60'h00000_00000_00000};
		for (int k = 0; k < 4; k++) begin
			for (int r = 0; r < 4; r++) write_reg(r[1:0], ext[(k + r) % 4]);
			send_ray(16'd0, 16'd0);
			send_ray(16'd32768, 16'd0);
			send_ray(16'd0, 16'd32768);
			send_ray(16'hFFFF, 16'hFFFF);
			send_ray(16'd32769, 16'd1);
			drain();
		end
		// Lower-left corner equal to the origin, away from zero.
		write_reg(crd_pkg::REG_ORIGIN, 60'h00400_00c00_00400);
		write_reg(crd_pkg::REG_LOWER_LEFT, 60'h00400_00c00_00400);
		write_reg(crd_pkg::REG_HORIZONTAL, 60'h0);
		write_reg(crd_pkg::REG_VERTICAL, 60'h00010_00000_00000);
		send_ray(16'd1234, 16'd0);
		send_ray(16'd1234, 16'd1);
		drain();
	endtask

	task automatic test_random_cameras();
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < 4; r++) write_reg(r[1:0], rand_vec());
			rx_stall_free = (ph % 3 == 2);
			for (int n = 0; n < 250; n++)
				send_ray(16'($urandom), 16'($urandom), ph % 3 == 2 && n < 100);
			drain();
		end
		rx_stall_free = 1'b0;
	endtask

	initial begin
		cam_regs = '{default: '0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_degenerate();
		test_extremes();
		test_random_cameras();
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ----- camera_ray_direction.f -----
+incdir+rtl
rtl/crd_pkg.sv
rtl/crd_front.sv
rtl/crd_norm.sv
rtl/crd_sqrt_stage.sv
rtl/crd_div_stage.sv
rtl/camera_ray_direction.sv
test/tb_camera_ray_direction.sv
